FILE: src/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

	localparam int COUNT_W = 5;
	localparam int LIMIT_W = 5;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} opcode_t;

	// per-operation flags from the tag array to the top level
	typedef struct packed {
		logic hit;
		logic evicted;
		logic val_we;
		logic rd_hit;
	} tag_resp_t;

endpackage

FILE: src/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/lkvc_tag.sv
// Key CAM with valid marks, recency ranks and entry count.
module lkvc_tag #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req,
	input  lkvc_pkg::opcode_t                 op,
	input  logic [KEY_BITS-1:0]               key,
	input  logic [lkvc_pkg::LIMIT_W-1:0]      limit,
	output lkvc_pkg::tag_resp_t               resp,
	output logic [KEY_BITS-1:0]               evicted_key,
	output logic [$clog2(ENTRIES)-1:0]        hit_idx,
	output logic [$clog2(ENTRIES)-1:0]        free_idx,
	output logic [$clog2(ENTRIES+1)-1:0]      count,
	output logic [$clog2(ENTRIES+1)-1:0]      count_next
);

	localparam int RW    = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lkvc_pkg::LIMIT_W) ? CNT_W : lkvc_pkg::LIMIT_W;

	logic [KEY_BITS-1:0] key_q [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [RW-1:0]       rank_q [ENTRIES];
	logic [CNT_W-1:0]    count_q;

	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  vict;
	logic [ENTRIES-1:0]  valid_mid;
	logic [ENTRIES-1:0]  free_oh;
	logic [ENTRIES-1:0]  valid_n;
	logic [RW-1:0]       rank_n [ENTRIES];
	logic [CNT_W-1:0]    count_n;
	logic [RW-1:0]       hit_rank;
	logic [RW-1:0]       rank_last;
	logic [CNT_W-1:0]    cnt_m1;
	logic [CMP_W-1:0]    lim_ext;
	logic [CMP_W-1:0]    lim_eff;
	logic                any_hit;
	logic                ins_new;
	logic                need_evict;
	logic                have_free;

	always_comb begin
		hit_rank    = '0;
		hit_idx     = '0;
		free_idx    = '0;
		evicted_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key);
		end
		any_hit = |match;
		ins_new = (op == lkvc_pkg::OP_INSERT) && !any_hit;

		// a limit of zero or above the store size means the whole store
		lim_ext = CMP_W'(limit);
		lim_eff = ((limit == '0) || (lim_ext > CMP_W'(ENTRIES))) ? CMP_W'(ENTRIES) : lim_ext;
		need_evict = ins_new && (CMP_W'(count_q) >= lim_eff) && (count_q != '0);

		// ranks have no gaps, so the least recent entry holds rank count-1
		cnt_m1    = count_q - CNT_W'(1);
		rank_last = cnt_m1[RW-1:0];
		for (int i = 0; i < ENTRIES; i++) begin
			vict[i] = need_evict && valid_q[i] && (rank_q[i] == rank_last);
		end
		valid_mid = valid_q & ~vict;
		free_oh   = ~valid_mid & (valid_mid + ENTRIES'(1));
		have_free = |free_oh;

		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_idx  = hit_idx | RW'(i);
			end
			if (free_oh[i]) begin
				free_idx = free_idx | RW'(i);
			end
			if (vict[i]) begin
				evicted_key = evicted_key | key_q[i];
			end
		end

		valid_n = valid_q;
		count_n = count_q;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_n[i] = rank_q[i];
		end

		unique case (op)
			lkvc_pkg::OP_LOOKUP, lkvc_pkg::OP_INSERT: begin
				if (any_hit) begin
					// promote the hit entry, age everything that was more recent
					for (int i = 0; i < ENTRIES; i++) begin
						if (match[i]) begin
							rank_n[i] = '0;
						end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
							rank_n[i] = rank_q[i] + RW'(1);
						end
					end
				end else if (op == lkvc_pkg::OP_INSERT) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (vict[i]) begin
							valid_n[i] = 1'b0;
							rank_n[i]  = '0;
						end else if (valid_mid[i] && have_free) begin
							rank_n[i] = rank_q[i] + RW'(1);
						end
						if (free_oh[i]) begin
							valid_n[i] = 1'b1;
							rank_n[i]  = '0;
						end
					end
					count_n = count_q - CNT_W'(need_evict) + CNT_W'(have_free);
				end
			end
			lkvc_pkg::OP_REMOVE: begin
				if (any_hit) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (match[i]) begin
							valid_n[i] = 1'b0;
							rank_n[i]  = '0;
						end else if (valid_q[i] && (rank_q[i] > hit_rank)) begin
							rank_n[i] = rank_q[i] - RW'(1);
						end
					end
					count_n = cnt_m1;
				end
			end
			default: begin
			end
		endcase

		resp.hit     = any_hit && ((op == lkvc_pkg::OP_LOOKUP) || (op == lkvc_pkg::OP_INSERT)
			|| (op == lkvc_pkg::OP_REMOVE));
		resp.evicted = need_evict;
		resp.val_we  = ins_new && have_free;
		resp.rd_hit  = (op == lkvc_pkg::OP_LOOKUP) && any_hit;
	end

	assign count      = count_q;
	assign count_next = count_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (req) begin
			valid_q <= valid_n;
			count_q <= count_n;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (req && ins_new && free_oh[i]) begin
				key_q[i] <= key;
			end
		end
	end

endmodule

FILE: src/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
// Fully associative key/value cache with least-recently-used replacement. Each word on the
// input channel is one operation (lookup, insert or remove) and gives exactly one word on the
// output channel: hit flag, read value, eviction flag and key, and the entry count after the
// operation. Each operation is registered at the input, all keys are compared in parallel
// against it and the recency ranks are updated in the same cycle, and the result lands in the
// output register, so one word per cycle is sustained while out_ready stays high; out_valid
// rises once the word has moved from the input register to the output register, which waits
// while the output register holds an undrained word. Keys, valid marks and ranks sit in
// flip-flops (the key compare is a CAM); values sit in a RAM whose registered read feeds the
// output word directly. Valid marks, ranks and the count clear at reset, so no clearing pass
// is needed. limit_q caps the number of held entries (0, or a value above ENTRIES, means the
// whole store); change it only while the block is idle. Lowering it below the current count
// does not purge anything: each later insert of a new key evicts a single entry.
module lru_key_value_cache_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [lkvc_pkg::LIMIT_W-1:0]  cfg_wdata,
	// operation words
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic [KEY_BITS-1:0]           key,
	input  logic [VALUE_BITS-1:0]         value,
	// result words
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [VALUE_BITS-1:0]         read_value,
	output logic                          evicted,
	output logic [KEY_BITS-1:0]           evicted_key,
	output logic [lkvc_pkg::COUNT_W-1:0]  entry_count
);

	localparam int IW     = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int OCNT_W = lkvc_pkg::COUNT_W;

	logic [lkvc_pkg::LIMIT_W-1:0] limit_q;

	// input stage
	logic                  v_s1;
	lkvc_pkg::opcode_t     op_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;

	// result stage
	logic                  out_valid_q;
	logic                  hit_s2;
	logic                  rd_hit_s2;
	logic                  evicted_s2;
	logic [KEY_BITS-1:0]   evicted_key_s2;
	logic [OCNT_W-1:0]     count_s2;
	logic [VALUE_BITS-1:0] ram_rdata;

	lkvc_pkg::tag_resp_t   resp;
	logic [KEY_BITS-1:0]   tag_evk;
	logic [IW-1:0]         hit_idx;
	logic [IW-1:0]         free_idx;
	logic [CNT_W-1:0]      cnt;
	logic [CNT_W-1:0]      cnt_next;
	logic                  fire;

	// advance the input word whenever the result register is empty or being drained
	assign fire     = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= lkvc_pkg::opcode_t'(opcode);
			key_s1   <= key;
			value_s1 <= value;
		end
	end

	lkvc_tag #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_tag (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (fire),
		.op          (op_s1),
		.key         (key_s1),
		.limit       (limit_q),
		.resp        (resp),
		.evicted_key (tag_evk),
		.hit_idx     (hit_idx),
		.free_idx    (free_idx),
		.count       (cnt),
		.count_next  (cnt_next)
	);

	// value store: write on a new insert, read the hit slot; read data holds while stalled
	lkvc_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (fire && resp.val_we),
		.waddr (free_idx),
		.wdata (value_s1),
		.re    (fire),
		.raddr (hit_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// the count in the word is the one after this operation
	always_ff @(posedge clk) begin
		if (fire) begin
			hit_s2         <= resp.hit;
			rd_hit_s2      <= resp.rd_hit;
			evicted_s2     <= resp.evicted;
			evicted_key_s2 <= tag_evk;
			count_s2       <= OCNT_W'(cnt_next);
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_s2;
	// only a lookup hit shows the stored value
	assign read_value  = rd_hit_s2 ? ram_rdata : '0;
	assign evicted     = evicted_s2;
	assign evicted_key = evicted_key_s2;
	assign entry_count = count_s2;

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("hit and eviction reported together");

	// a nonzero read value only comes with a hit
	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (read_value != '0)) |-> hit)
		else $error("read value without hit");

	// the count never passes the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(ENTRIES) >= cnt)
		else $error("entry count beyond store size");

	// an eviction frees the slot that the new entry takes, so the count holds
	a_evict_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && resp.evicted) |=> (cnt == $past(cnt)))
		else $error("count changed across an eviction");

endmodule

FILE: tb/lru_key_value_cache_unit_test.sv
// Testbench for the LRU key/value cache: predicts every result word and checks it.
`timescale 1ns / 100ps

module lru_key_value_cache_unit_test;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	// opcode 3 is not an operation; the block must answer it with no hit, value or eviction, only the count
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int LONG_STALL  = 150;     // receiver hold-off, well past the block's buffering
	localparam int CYCLE_LIMIT = 400000;  // generous ceiling for the slowest legal run
	localparam int MAX_SHOWN   = 10;

	typedef struct packed {
		logic                            hit;
		logic [VALUE_BITS-1:0]           read_value;
		logic                            evicted;
		logic [KEY_BITS-1:0]             evicted_key;
		logic [lkvc_pkg::COUNT_W-1:0]    entry_count;
	} result_word_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lkvc_pkg::LIMIT_W-1:0]    cfg_wdata;
	logic                            in_valid;
	logic                            in_ready;
	logic [1:0]                      opcode;
	logic [KEY_BITS-1:0]             key;
	logic [VALUE_BITS-1:0]           value;
	logic                            out_valid;
	logic                            out_ready;
	logic                            hit;
	logic [VALUE_BITS-1:0]           read_value;
	logic                            evicted;
	logic [KEY_BITS-1:0]             evicted_key;
	logic [lkvc_pkg::COUNT_W-1:0]    entry_count;

	// shadow copy of the cache contents
	logic [KEY_BITS-1:0]             shadow_key[ENTRIES];
	logic [VALUE_BITS-1:0]           shadow_value[ENTRIES];
	bit                              shadow_used[ENTRIES];
	int unsigned                     shadow_rank[ENTRIES];
	int unsigned                     shadow_count;
	logic [lkvc_pkg::LIMIT_W-1:0]    shadow_limit;

	result_word_t           awaited_words[$];
	int                     error_count;
	int                     cycle_count;
	bit                     tx_calm;      // sender offers back to back when set
	int                     stall_token;  // bump to request one long receiver hold-off
	logic [KEY_BITS-1:0]    key_pool[24];

	lru_key_value_cache_unit #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.entry_count (entry_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// Move a slot to the front: everything that was more recent ages by one.
	function automatic void make_newest(int s);
		int unsigned r;
		r = shadow_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_used[i] && shadow_rank[i] < r)
				shadow_rank[i]++;
		shadow_rank[s] = 0;
	endfunction

	// Invalidate a slot and close the gap it leaves in the ranks.
	function automatic void retire_slot(int s);
		int unsigned r;
		r = shadow_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_used[i] && shadow_rank[i] > r)
				shadow_rank[i]--;
		shadow_used[s] = 1'b0;
		shadow_rank[s] = 0;
		if (shadow_count > 0)
			shadow_count--;
	endfunction

	// Apply one operation to the shadow cache and return the word it must produce.
	function automatic result_word_t cache_apply(logic [1:0] op, logic [KEY_BITS-1:0] k,
			logic [VALUE_BITS-1:0] v);
		result_word_t w;
		int s;
		int oldest;
		int free_slot;
		int unsigned cap;
		w = '0;
		s = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (s < 0 && shadow_used[i] && shadow_key[i] == k)
				s = i;
		if (op == lkvc_pkg::OP_LOOKUP || op == lkvc_pkg::OP_INSERT ||
				op == lkvc_pkg::OP_REMOVE) begin
			w.hit = (s >= 0);
			if (op == lkvc_pkg::OP_LOOKUP) begin
				if (s >= 0) begin
					make_newest(s);
					w.read_value = shadow_value[s];
				end
			end else if (op == lkvc_pkg::OP_REMOVE) begin
				if (s >= 0)
					retire_slot(s);
			end else if (s >= 0) begin
				// present key: promote only, the old value stays
				make_newest(s);
			end else begin
				cap = shadow_limit;
				if (cap == 0 || cap > ENTRIES)
					cap = ENTRIES;
				// a single eviction at most, even when the limit sits below the count
				if (shadow_count >= cap && shadow_count > 0) begin
					oldest = -1;
					for (int i = 0; i < ENTRIES; i++)
						if (shadow_used[i] &&
								(oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
							oldest = i;
					if (oldest >= 0) begin
						w.evicted = 1'b1;
						w.evicted_key = shadow_key[oldest];
						retire_slot(oldest);
					end
				end
				free_slot = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (free_slot < 0 && !shadow_used[i])
						free_slot = i;
				if (free_slot >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (shadow_used[i])
							shadow_rank[i]++;
					shadow_key[free_slot] = k;
					shadow_value[free_slot] = v;
					shadow_used[free_slot] = 1'b1;
					shadow_rank[free_slot] = 0;
					shadow_count++;
				end
			end
		end
		w.entry_count = shadow_count[lkvc_pkg::COUNT_W-1:0];
		return w;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void note_error(string msg);
		error_count++;
		if (error_count <= MAX_SHOWN)
			$display("%s", msg);
	endfunction

	function automatic string fmt_word(result_word_t w);
		return $sformatf("hit=%0b val=%h ev=%0b evk=%h cnt=%0d",
			w.hit, w.read_value, w.evicted, w.evicted_key, w.entry_count);
	endfunction

	// Sample the result channel at each edge; pre-edge values are seen here.
	always @(posedge clk) begin
		result_word_t want;
		result_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {hit, read_value, evicted, evicted_key, entry_count};
			if (awaited_words.size() == 0) begin
				note_error({"unexpected result word: ", fmt_word(got)});
			end else begin
				want = awaited_words.pop_front();
				if (got !== want)
					note_error({"mismatch: expected ", fmt_word(want),
						", got ", fmt_word(got)});
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- drivers

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Receiver: random gaps, calm stretches, and a long hold-off on request.
	initial begin : ready_driver
		int stall_seen;
		int gap_left;
		int calm_left;
		stall_seen = 0;
		gap_left = 0;
		calm_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_token != stall_seen) begin
				// hold off long enough that the block fills and stalls its input
				stall_seen = stall_token;
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end else if (gap_left > 0) begin
				out_ready <= 1'b0;
				gap_left--;
			end else begin
				out_ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 49) == 0)
					calm_left = $urandom_range(40, 100);
				else if ($urandom_range(0, 3) == 0)
					gap_left = pick_gap();
			end
		end
	end

	// Offer one word, hold it until taken, then record what it must produce.
	task automatic send_word(logic [1:0] op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		awaited_words.push_back(cache_apply(op, k, v));
		gap = 0;
		if (!tx_calm && $urandom_range(0, 2) == 0)
			gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every awaited word is back, plus the pipeline depth.
	task automatic drain();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the limit register only once the block is idle.
	task automatic write_limit(logic [lkvc_pkg::LIMIT_W-1:0] lim);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_limit = lim;
	endtask

	// ---------------------------------------------------------------- tests

	// Corner words on the whole store: empty store, all-zero and all-one fields,
	// re-insert of a present key, repeated remove, and the unused opcode.
	task automatic test_directed();
		send_word(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		send_word(lkvc_pkg::OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		send_word(lkvc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(lkvc_pkg::OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
		send_word(lkvc_pkg::OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
		send_word(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
		send_word(lkvc_pkg::OP_INSERT, 32'h5555_5555, 32'h1234_5678);
		send_word(lkvc_pkg::OP_LOOKUP, 32'h5555_5555, 32'h0000_0000);
		send_word(OP_UNUSED, 32'h5555_5555, 32'h0000_0000);
		send_word(lkvc_pkg::OP_REMOVE, 32'hAAAA_AAAA, 32'h0000_0000);
		send_word(lkvc_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000);
		send_word(lkvc_pkg::OP_REMOVE, 32'hAAAA_AAAA, 32'h0000_0000);
		send_word(lkvc_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
		send_word(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(lkvc_pkg::OP_INSERT, 32'h8000_0001, 32'h7FFF_FFFE);
		send_word(lkvc_pkg::OP_LOOKUP, 32'h8000_0001, 32'h0000_0000);
	endtask

	// Limit extremes: lower below the count (one eviction per insert), all ones
	// and just past the store (both act as the whole store), zero, and small.
	task automatic test_limit_extremes();
		logic [lkvc_pkg::LIMIT_W-1:0] lims[5];
		int n;
		lims = '{5'd1, 5'd31, 5'd17, 5'd0, 5'd2};
		foreach (lims[j]) begin
			write_limit(lims[j]);
			n = (lims[j] == 5'd1 || lims[j] == 5'd2) ? 6 : 18;
			for (int i = 0; i < n; i++)
				send_word(lkvc_pkg::OP_INSERT, $urandom(), $urandom());
		end
	endtask

	// Fill the block against a stalled receiver, then pause until all is back.
	task automatic test_backpressure();
		write_limit(5'd4);
		tx_calm = 1'b1;
		stall_token <= stall_token + 1;
		for (int i = 0; i < 40; i++)
			send_word((i % 3 == 2) ? lkvc_pkg::OP_LOOKUP : lkvc_pkg::OP_INSERT,
				key_pool[i % 6], $urandom());
		tx_calm = 1'b0;
		drain();
	endtask

	// Random operations over a small key pool so that hits and evictions are common.
	task automatic test_random_ops();
		logic [lkvc_pkg::LIMIT_W-1:0] lim_menu[8];
		logic [1:0] op;
		logic [KEY_BITS-1:0] k;
		int r;
		int pool_used;
		lim_menu = '{5'd0, 5'd1, 5'd3, 5'd8, 5'd15, 5'd16, 5'd31, 5'd5};
		for (int phase = 0; phase < 6; phase++) begin
			write_limit((phase == 5) ? lkvc_pkg::LIMIT_W'($urandom_range(0, 31)) :
				lim_menu[$urandom_range(0, 7)]);
			foreach (key_pool[j])
				key_pool[j] = $urandom();
			pool_used = $urandom_range(4, 23);
			tx_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 64; i++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					op = lkvc_pkg::OP_INSERT;
				else if (r < 80)
					op = lkvc_pkg::OP_LOOKUP;
				else if (r < 95)
					op = lkvc_pkg::OP_REMOVE;
				else
					op = OP_UNUSED;
				k = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, pool_used)] :
					$urandom();
				send_word(op, k, $urandom());
			end
			tx_calm = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		error_count = 0;
		cycle_count = 0;
		tx_calm = 1'b0;
		stall_token = 0;
		shadow_count = 0;
		shadow_limit = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_key[i] = '0;
			shadow_value[i] = '0;
			shadow_used[i] = 1'b0;
			shadow_rank[i] = 0;
		end
		foreach (key_pool[j])
			key_pool[j] = $urandom();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		opcode <= lkvc_pkg::OP_LOOKUP;
		key <= '0;
		value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_limit_extremes();
		test_backpressure();
		test_random_ops();
		test_backpressure();

		drain();
		repeat (8) @(posedge clk);
		if (error_count == 0 && awaited_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
